[hdl/rodht_pkg.sv]
`timescale 1ns / 1ps

package rodht_pkg;

  // Field widths fixed by the stream format
  localparam int MASK_W   = 16;
  localparam int IN_TDATA_W  = 4 * MASK_W;
  localparam int OUT_TDATA_W = 2 * MASK_W;
  localparam int TICKS_W  = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;

  // Default sizing
  localparam int DEF_CHANNELS   = 16;
  localparam int DEF_COUNT_BITS = 16;

  // Register values after reset
  localparam logic [TICKS_W-1:0] RST_DELAY_TICKS   = 16'd1;
  localparam logic               RST_DELAY_RESTART = 1'b1;
  localparam logic [TICKS_W-1:0] RST_HOLD_TICKS    = 16'd150;
  localparam logic               RST_HOLD_RESTART  = 1'b1;
  localparam logic [MASK_W-1:0]  RST_INVERT_MASK   = 16'h000F;

  // Register indexes on the configuration port
  typedef enum logic [CFG_AW-1:0] {
    REG_DELAY_TICKS   = 3'd0,
    REG_DELAY_RESTART = 3'd1,
    REG_HOLD_TICKS    = 3'd2,
    REG_HOLD_RESTART  = 3'd3,
    REG_INVERT_MASK   = 3'd4
  } reg_idx_t;

  // Timer settings shared by every lane
  typedef struct packed {
    logic [TICKS_W-1:0] delay_ticks;
    logic               delay_restart;
    logic [TICKS_W-1:0] hold_ticks;
    logic               hold_restart;
  } timer_cfg_t;

  // One tick's event masks as seen by the lanes
  typedef struct packed {
    logic [MASK_W-1:0] activate;
    logic [MASK_W-1:0] deactivate;
  } event_t;

endpackage

[hdl/rodht_lane.sv]
`timescale 1ns / 1ps

module rodht_lane
  import rodht_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,       // tick accepted this cycle
  input  timer_cfg_t cfg,
  input  logic       on_i,       // stored channel state
  input  logic       act,
  input  logic       dea,
  output logic       on_o        // channel state before the force masks
);

  localparam int WB = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
  localparam logic [WB-1:0] CNT_MAX_W = WB'({COUNT_BITS{1'b1}});

  logic [COUNT_BITS-1:0] dc_r, dc_nxt;
  logic [COUNT_BITS-1:0] hc_r, hc_nxt;
  logic [WB-1:0]         delay_ext, hold_ext;
  logic [COUNT_BITS-1:0] delay_load, hold_load;
  logic                  delay_zero, hold_zero;

  // Saturate the settings to the counter width
  assign delay_ext  = WB'(cfg.delay_ticks);
  assign hold_ext   = WB'(cfg.hold_ticks);
  assign delay_load = COUNT_BITS'((delay_ext > CNT_MAX_W) ? CNT_MAX_W : delay_ext);
  assign hold_load  = COUNT_BITS'((hold_ext > CNT_MAX_W) ? CNT_MAX_W : hold_ext);
  assign delay_zero = (cfg.delay_ticks == '0);
  assign hold_zero  = (cfg.hold_ticks == '0);

  // Load a counter: clear on zero setting, reload when idle or restartable
  function automatic logic [COUNT_BITS-1:0] start_cnt(
    input logic [COUNT_BITS-1:0] cnt,
    input logic [COUNT_BITS-1:0] load,
    input logic                  zero,
    input logic                  restart
  );
    logic [COUNT_BITS-1:0] res;
    res = cnt;
    if (zero) begin
      res = '0;
    end else if (cnt == '0 || restart) begin
      res = load;
    end
    return res;
  endfunction

  // Walk the per-tick rules in order
  always_comb begin
    logic on;
    on     = on_i;
    dc_nxt = dc_r;
    hc_nxt = hc_r;
    if (dea) begin
      on     = 1'b0;
      dc_nxt = '0;
      hc_nxt = '0;
    end
    if (act) begin
      if (!on) begin
        if (delay_zero) begin
          on     = 1'b1;
          hc_nxt = start_cnt(hc_nxt, hold_load, hold_zero, cfg.hold_restart);
        end else begin
          dc_nxt = start_cnt(dc_nxt, delay_load, delay_zero, cfg.delay_restart);
        end
      end else if (!hold_zero) begin
        hc_nxt = start_cnt(hc_nxt, hold_load, hold_zero, cfg.hold_restart);
      end
    end
    if (!on && dc_nxt != '0) begin
      dc_nxt = dc_nxt - 1'b1;
      if (dc_nxt == '0) begin
        on     = 1'b1;
        hc_nxt = start_cnt(hc_nxt, hold_load, hold_zero, cfg.hold_restart);
      end
    end
    if (on && !hold_zero && hc_nxt != '0) begin
      hc_nxt = hc_nxt - 1'b1;
      if (hc_nxt == '0) begin
        on = 1'b0;
      end
    end
    on_o = on;
  end

  // Advance the counters once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= '0;
      hc_r <= '0;
    end else if (step) begin
      dc_r <= dc_nxt;
      hc_r <= hc_nxt;
    end
  end

endmodule

[hdl/rodht_merge.sv]
`timescale 1ns / 1ps

module rodht_merge
  import rodht_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [CHANNELS-1:0]    lane_on,
  input  logic [CHANNELS-1:0]    force_on,
  input  logic [CHANNELS-1:0]    force_off,
  input  logic [MASK_W-1:0]      invert_mask,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [CHANNELS-1:0]    active_o
);

  logic [CHANNELS-1:0]    active_r, active_nxt;
  logic [MASK_W-1:0]      states_w;
  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;

  // Combine lanes, force off wins over force on
  assign active_nxt = (lane_on | force_on) & ~force_off;
  assign states_w   = MASK_W'(active_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (step) begin
      active_r <= active_nxt;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_r <= {(states_w ^ invert_mask) & MASK_W'({CHANNELS{1'b1}}), states_w};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign active_o   = active_r;

endmodule

[hdl/relay_output_delay_hold_timers_core.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in_      sink       in_tvalid/in_tready    activate, deactivate, force on, force off
// out_     source     out_tvalid/out_tready  channel states, pin levels
// cfg_     sink       cfg_we                 register index, write data
//
// One tick word is taken per clock while in_tready is high; its result is
// registered in the output register as the word is taken. All channel lanes
// update in parallel in that cycle and feed the merge register.
// Reset clears channel states, all counters and restores register defaults.
// in_tready drops only while a result sits unaccepted and out_tready is low.

module relay_output_delay_hold_timers_core
  import rodht_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // [15:0] activate_mask, [31:16] deactivate_mask,
  // [47:32] force_on_mask, [63:48] force_off_mask
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] channel_states, [31:16] pin_levels
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  timer_cfg_t           cfg_r;
  logic [MASK_W-1:0]    invert_r;
  logic                 step;
  event_t               ev;
  logic [CHANNELS-1:0]  lane_on;
  logic [CHANNELS-1:0]  active;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks   <= RST_DELAY_TICKS;
      cfg_r.delay_restart <= RST_DELAY_RESTART;
      cfg_r.hold_ticks    <= RST_HOLD_TICKS;
      cfg_r.hold_restart  <= RST_HOLD_RESTART;
      invert_r            <= RST_INVERT_MASK;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DELAY_TICKS:   cfg_r.delay_ticks   <= cfg_wdata[TICKS_W-1:0];
        REG_DELAY_RESTART: cfg_r.delay_restart <= cfg_wdata[0];
        REG_HOLD_TICKS:    cfg_r.hold_ticks    <= cfg_wdata[TICKS_W-1:0];
        REG_HOLD_RESTART:  cfg_r.hold_restart  <= cfg_wdata[0];
        REG_INVERT_MASK:   invert_r            <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a tick whenever the output register is free or draining
  assign in_tready = !out_tvalid || out_tready;
  assign step      = in_tvalid && in_tready;

  assign ev.activate   = in_tdata[MASK_W-1:0];
  assign ev.deactivate = in_tdata[2*MASK_W-1:MASK_W];

  // One timer lane per channel
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    rodht_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .cfg   (cfg_r),
      .on_i  (active[ch]),
      .act   (ev.activate[ch]),
      .dea   (ev.deactivate[ch]),
      .on_o  (lane_on[ch])
    );
  end

  rodht_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .lane_on     (lane_on),
    .force_on    (in_tdata[2*MASK_W +: CHANNELS]),
    .force_off   (in_tdata[3*MASK_W +: CHANNELS]),
    .invert_mask (invert_r),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .active_o    (active)
  );

endmodule
